// ----- hw/rtl/jes_pkg.sv -----
package jes_pkg;

  localparam int DEFAULT_MAX_NEST = 32;
  localparam int DEPTH_W   = 6;
  localparam int VALUE_W   = 64;
  localparam int DIGITS    = 20;
  localparam int BCD_W     = DIGITS * 4;
  localparam int BIT_CNT_W = $clog2(VALUE_W);
  localparam int DIG_CNT_W = $clog2(DIGITS + 1);
  localparam int BODY_LEN  = 5;
  localparam int TEXT_LEN  = BODY_LEN + 1;
  localparam int TEXT_N_W  = $clog2(TEXT_LEN + 1);

  typedef enum logic [3:0] {
    CMD_DOC_BEGIN = 4'd0,
    CMD_DOC_END   = 4'd1,
    CMD_UINT      = 4'd2,
    CMD_BOOL      = 4'd3,
    CMD_STR_BEGIN = 4'd4,
    CMD_KEY_BEGIN = 4'd5,
    CMD_STR_BYTE  = 4'd6,
    CMD_STR_END   = 4'd7,
    CMD_ARR_BEGIN = 4'd8,
    CMD_ARR_END   = 4'd9,
    CMD_OBJ_BEGIN = 4'd10,
    CMD_OBJ_END   = 4'd11
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_TEXT,
    S_DIGITS
  } state_t;

  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_L      = 8'h6c;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] RAW_BS  = 8'h08;
  localparam logic [7:0] RAW_TAB = 8'h09;
  localparam logic [7:0] RAW_LF  = 8'h0a;
  localparam logic [7:0] RAW_FF  = 8'h0c;
  localparam logic [7:0] RAW_CR  = 8'h0d;

endpackage

// ----- hw/rtl/jes_evt_if.sv -----
interface jes_evt_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [63:0] value;
  logic [7:0]  char_byte;

  modport source(output valid, command, value, char_byte, input ready);
  modport sink(input valid, command, value, char_byte, output ready);
endinterface

// ----- hw/rtl/jes_txt_if.sv -----
interface jes_txt_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source(output valid, out_byte, last, error, input ready);
  modport sink(input valid, out_byte, last, error, output ready);
endinterface

// ----- hw/rtl/json_event_serializer.sv -----
// JSON event serializer.
// evt: one writer event per transfer (command, value, char_byte).
// txt: the JSON text, one byte per transfer; last marks the final byte of an
//   event, error marks the single zero byte sent for a bad event.
// Doc begin sends nothing; doc end sends nothing unless the error flag is set.
// Other events but numbers: the event is taken, then the bytes go out one per
//   cycle while txt is ready (at most 6 bytes, e.g. ",false").
// Unsigned numbers: all 64 bits pass through the shift-add-3 binary to decimal
//   unit, then the comma goes out if any, then the 20-digit register is walked:
//   leading zeros are skipped at one per cycle, digits go out one per cycle while txt is ready.
// evt.ready is high only while no event is in progress; the next event may
//   be taken while the last byte still sits in the output register.
// A stall on txt holds the byte in the output register and holds the
//   sequencer while it has a byte to send; nothing is dropped.
// Reset: depth 0, first-element flag set, no string open, no error.
// The error flag is sticky: every event but doc begin then gives one error
//   byte until a doc begin clears it.
module json_event_serializer
  import jes_pkg::*;
#(
  parameter int MAX_NEST = DEFAULT_MAX_NEST
) (
  input logic          clk,
  input logic          rst,
  jes_evt_if.sink      evt,
  jes_txt_if.source    txt
);

  state_t state, state_next;

  logic [DEPTH_W-1:0] nest_depth, depth_next;
  logic               first_in_container, first_next;
  logic               string_is_key, key_next;
  logic [2:0]         utf8_pending, pend_next;
  logic               sticky_error, sticky_next;

  logic [TEXT_LEN-1:0][7:0] text;
  logic [TEXT_N_W-1:0]      text_n;
  logic                     item_err;
  logic                     do_digits;
  logic [VALUE_W-1:0]       bin;
  logic [BCD_W-1:0]         bcd;
  logic [BIT_CNT_W-1:0]     bit_cnt;
  logic [DIG_CNT_W-1:0]     dig_rem;
  logic                     started;

  logic       out_valid;
  logic [7:0] out_data;
  logic       out_last;
  logic       out_err;

  // decode of the offered event
  logic [BODY_LEN-1:0][7:0] body;
  logic [TEXT_N_W-1:0]      body_n;
  logic                     sep_on;
  logic                     dec_err;
  logic                     dec_digits;
  logic [TEXT_LEN-1:0][7:0] dec_text;
  logic [TEXT_N_W-1:0]      dec_n;
  logic [7:0]               c;
  logic [2:0]               owed;

  logic                     accept;
  logic                     can_emit;
  logic                     emit;
  logic [7:0]               emit_byte;
  logic                     emit_last;
  logic                     emit_err;
  logic [BCD_W-1:0]         bcd_adj;
  logic [3:0]               top_digit;
  logic                     digit_now;

  assign accept   = evt.valid && evt.ready;
  assign can_emit = !out_valid || txt.ready;
  assign c        = evt.char_byte;

  always_comb begin
    body        = '0;
    body_n      = '0;
    sep_on      = 1'b0;
    dec_err     = 1'b0;
    dec_digits  = 1'b0;
    owed        = 3'd0;
    depth_next  = nest_depth;
    first_next  = first_in_container;
    key_next    = string_is_key;
    pend_next   = utf8_pending;
    sticky_next = sticky_error;

    if (evt.command == CMD_DOC_BEGIN) begin
      depth_next  = DEPTH_W'(1);
      first_next  = 1'b1;
      key_next    = 1'b0;
      pend_next   = 3'd0;
      sticky_next = 1'b0;
    end else if (sticky_error) begin
      dec_err = 1'b1;
    end else begin
      case (evt.command)
        CMD_DOC_END: begin
        end
        CMD_UINT: begin
          sep_on     = !first_in_container;
          first_next = 1'b0;
          dec_digits = 1'b1;
        end
        CMD_BOOL: begin
          sep_on     = !first_in_container;
          first_next = 1'b0;
          if (evt.value[0]) begin
            body[0] = CH_T; body[1] = CH_R; body[2] = CH_U; body[3] = CH_E;
            body_n  = TEXT_N_W'(4);
          end else begin
            body[0] = CH_F; body[1] = CH_A; body[2] = CH_L; body[3] = CH_S;
            body[4] = CH_E;
            body_n  = TEXT_N_W'(5);
          end
        end
        CMD_STR_BEGIN, CMD_KEY_BEGIN: begin
          sep_on     = !first_in_container;
          first_next = 1'b0;
          body[0]    = CH_QUOTE;
          body_n     = TEXT_N_W'(1);
          key_next   = (evt.command == CMD_KEY_BEGIN);
          pend_next  = 3'd0;
        end
        CMD_STR_BYTE: begin
          if (utf8_pending != 3'd0) begin
            if (c[7:6] != 2'b10) begin
              dec_err = 1'b1;
            end else begin
              body[0]   = c;
              body_n    = TEXT_N_W'(1);
              pend_next = utf8_pending - 3'd1;
            end
          end else if (c inside {[8'h20:8'h7e]}) begin
            if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH) begin
              body[0] = CH_BSLASH;
              body[1] = c;
              body_n  = TEXT_N_W'(2);
            end else begin
              body[0] = c;
              body_n  = TEXT_N_W'(1);
            end
          end else begin
            body[0] = CH_BSLASH;
            body_n  = TEXT_N_W'(2);
            case (c)
              RAW_BS:  body[1] = CH_B;
              RAW_FF:  body[1] = CH_F;
              RAW_LF:  body[1] = CH_N;
              RAW_CR:  body[1] = CH_R;
              RAW_TAB: body[1] = CH_T;
              default: begin
                // lead byte of a multi-byte sequence, or invalid
                if ((c & 8'he0) == 8'hc0)      owed = 3'd1;
                else if ((c & 8'hf0) == 8'he0) owed = 3'd2;
                else if ((c & 8'hf8) == 8'hf0) owed = 3'd3;
                else if ((c & 8'hfc) == 8'hf8) owed = 3'd4;
                else if ((c & 8'hfe) == 8'hfc) owed = 3'd5;
                if (owed == 3'd0) begin
                  dec_err = 1'b1;
                end else begin
                  body[0]   = c;
                  body[1]   = 8'h00;
                  body_n    = TEXT_N_W'(1);
                  pend_next = owed;
                end
              end
            endcase
          end
        end
        CMD_STR_END: begin
          if (utf8_pending != 3'd0) begin
            dec_err = 1'b1;
          end else begin
            body[0] = CH_QUOTE;
            body_n  = TEXT_N_W'(1);
            if (string_is_key) begin
              body[1]    = CH_COLON;
              body_n     = TEXT_N_W'(2);
              first_next = 1'b1;
            end
            key_next = 1'b0;
          end
        end
        CMD_ARR_BEGIN, CMD_OBJ_BEGIN: begin
          if (nest_depth >= DEPTH_W'(MAX_NEST)) begin
            dec_err = 1'b1;
          end else begin
            sep_on     = !first_in_container;
            body[0]    = (evt.command == CMD_ARR_BEGIN) ? CH_LBRACK : CH_LBRACE;
            body_n     = TEXT_N_W'(1);
            depth_next = nest_depth + DEPTH_W'(1);
            first_next = 1'b1;
          end
        end
        CMD_ARR_END, CMD_OBJ_END: begin
          if (nest_depth <= DEPTH_W'(1)) begin
            dec_err = 1'b1;
          end else begin
            body[0]    = (evt.command == CMD_ARR_END) ? CH_RBRACK : CH_RBRACE;
            body_n     = TEXT_N_W'(1);
            depth_next = nest_depth - DEPTH_W'(1);
            first_next = (nest_depth == DEPTH_W'(2));
          end
        end
        default: dec_err = 1'b1;
      endcase
    end

    if (dec_err) begin
      depth_next  = nest_depth;
      first_next  = first_in_container;
      key_next    = string_is_key;
      pend_next   = utf8_pending;
      sticky_next = 1'b1;
      dec_digits  = 1'b0;
      dec_text    = '0;
      dec_n       = TEXT_N_W'(1);
    end else if (sep_on) begin
      dec_text = {body, CH_COMMA};
      dec_n    = body_n + TEXT_N_W'(1);
    end else begin
      dec_text = {8'h00, body};
      dec_n    = body_n;
    end
  end

  // shift-add-3 step: digits of 5 or more get 3 added before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      else                       bcd_adj[4*i +: 4] = bcd[4*i +: 4];
    end
  end

  assign top_digit = bcd[BCD_W-1 -: 4];
  assign digit_now = started || (top_digit != 4'd0) || (dig_rem == DIG_CNT_W'(1));

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_byte  = text[0];
    emit_last  = 1'b0;
    emit_err   = item_err;
    case (state)
      S_IDLE: begin
        if (accept && (dec_err || dec_digits || dec_n != '0)) begin
          state_next = dec_digits ? S_CONV : S_TEXT;
        end
      end
      S_CONV: begin
        if (bit_cnt == '1) begin
          state_next = (text_n != '0) ? S_TEXT : S_DIGITS;
        end
      end
      S_TEXT: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_last = (text_n == TEXT_N_W'(1)) && !do_digits;
          if (text_n == TEXT_N_W'(1)) begin
            state_next = do_digits ? S_DIGITS : S_IDLE;
          end
        end
      end
      S_DIGITS: begin
        emit_byte = CH_ZERO | {4'd0, top_digit};
        emit_err  = 1'b0;
        emit_last = (dig_rem == DIG_CNT_W'(1));
        if (digit_now && can_emit) begin
          emit = 1'b1;
          if (dig_rem == DIG_CNT_W'(1)) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nest_depth         <= '0;
      first_in_container <= 1'b1;
      string_is_key      <= 1'b0;
      utf8_pending       <= 3'd0;
      sticky_error       <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (accept) begin
        nest_depth         <= depth_next;
        first_in_container <= first_next;
        string_is_key      <= key_next;
        utf8_pending       <= pend_next;
        sticky_error       <= sticky_next;
      end
      if (emit)           out_valid <= 1'b1;
      else if (txt.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_byte;
      out_last <= emit_last;
      out_err  <= emit_err;
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          text      <= dec_text;
          text_n    <= dec_n;
          item_err  <= dec_err;
          do_digits <= dec_digits;
          bin       <= evt.value;
          bcd       <= '0;
          bit_cnt   <= '0;
          dig_rem   <= DIG_CNT_W'(DIGITS);
          started   <= 1'b0;
        end
      end
      S_CONV: begin
        bcd     <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
        bin     <= {bin[VALUE_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      end
      S_TEXT: begin
        if (emit) begin
          text   <= {8'h00, text[TEXT_LEN-1:1]};
          text_n <= text_n - TEXT_N_W'(1);
        end
      end
      S_DIGITS: begin
        // leading zeros are dropped without waiting for the sink
        if (emit || !digit_now) begin
          bcd     <= {bcd[BCD_W-5:0], 4'd0};
          dig_rem <= dig_rem - DIG_CNT_W'(1);
          started <= started || emit;
        end
      end
      default: begin
      end
    endcase
  end

  // no transfer is taken while reset is held
  assign evt.ready    = !rst && (state == S_IDLE);
  assign txt.valid    = out_valid;
  assign txt.out_byte = out_data;
  assign txt.last     = out_last;
  assign txt.error    = out_err;

`ifndef SYNTHESIS
  a_err_byte: assert property (@(posedge clk) disable iff (rst)
    txt.valid && txt.error |-> (txt.out_byte == 8'h00) && txt.last)
    else $error("error transfer without zero byte and last");

  a_depth_max: assert property (@(posedge clk) disable iff (rst)
    nest_depth <= DEPTH_W'(MAX_NEST))
    else $error("nesting depth beyond limit");

  a_uint_conv: assert property (@(posedge clk) disable iff (rst)
    accept && (evt.command == CMD_UINT) && !sticky_error |=> state == S_CONV)
    else $error("number event did not start conversion");

  a_utf8_range: assert property (@(posedge clk) disable iff (rst)
    utf8_pending <= 3'd5)
    else $error("continuation count out of range");
`endif

endmodule
